>>> hdl/pri_pkg.sv
// Shared types and constants for the permutation rank unit.
// Used by pri_cell, permutation_rank_index and the port checker.
`default_nettype none

package pri_pkg;

    localparam int N        = 8;
    localparam int NIBBLES  = 8;
    // positions actually handled: capped by the eight nibbles of the input
    localparam int CAP      = (N < NIBBLES) ? N : NIBBLES;
    localparam int POS_W    = $clog2(CAP);
    localparam int NIB_W    = 4;
    localparam int IMG_W    = 32;
    localparam int INDEX_W  = 16;
    localparam int SIZE_W   = 4;
    localparam int SEEN_W   = 1 << NIB_W;

    localparam logic [SIZE_W-1:0]  ACTIVE_N_RST = SIZE_W'(8);
    localparam logic [INDEX_W-1:0] INDEX_LIMIT  = INDEX_W'(40320);

    // m! for m = 0..7
    localparam logic [INDEX_W-1:0] FACT [NIBBLES] = '{
        16'd1, 16'd1, 16'd2, 16'd6, 16'd24, 16'd120, 16'd720, 16'd5040
    };

    typedef struct packed {
        logic [IMG_W-1:0]   images;
        logic [SEEN_W-1:0]  seen;
        logic               bad;
        logic [INDEX_W-1:0] rank;
    } t_lane;

endpackage

`default_nettype wire

>>> hdl/permutation_rank_index.sv
// Permutation rank (Lehmer code) unit: top level with the size register.
// Depends on pri_pkg and pri_cell.
//
// Input channel: i_valid / o_stall carry i_images, nibble k-1 holding the
// image of position k. Output channel: o_valid / i_stall carry o_index and
// o_not_permutation, one result per input transaction, in order.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into active_n (reset 8);
// a size of 0 counts as 1, sizes above the cell count saturate.
// The datapath is a chain of eight cells, one per position; each cell checks
// its image and adds digit * m! to the running rank. A transaction passes the
// register of each cell in turn; throughput is one transaction per cycle when
// the receiver does not stall, set by the one-register-per-cell chain.
// A stall from the receiver holds the last cell, and the stall ripples back
// only through cells that are full, so empty slots keep filling. o_stall
// rises only when every cell holds a result.
// Reset (synchronous, active low) empties the chain and restores active_n.
`default_nettype none

module permutation_rank_index (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire  [pri_pkg::SIZE_W-1:0]  i_cfg_wr_data,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire  [pri_pkg::IMG_W-1:0]   i_images,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [pri_pkg::INDEX_W-1:0] o_index,
    output logic                        o_not_permutation
);

    localparam logic [pri_pkg::SIZE_W-1:0] SIZE_CAP = pri_pkg::SIZE_W'(pri_pkg::CAP);

    logic [pri_pkg::SIZE_W-1:0] r_active_n;
    logic [pri_pkg::SIZE_W-1:0] size_eff;

    pri_pkg::t_lane lane  [pri_pkg::CAP+1];
    logic           valid [pri_pkg::CAP+1];
    logic           stall [pri_pkg::CAP+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_n <= pri_pkg::ACTIVE_N_RST;
        end else if (i_cfg_wr_en) begin
            r_active_n <= i_cfg_wr_data;
        end
    end

    always_comb begin
        if (r_active_n == '0) begin
            size_eff = pri_pkg::SIZE_W'(1);
        end else if (r_active_n > SIZE_CAP) begin
            size_eff = SIZE_CAP;
        end else begin
            size_eff = r_active_n;
        end
    end

    assign lane[0].images = i_images;
    assign lane[0].seen   = '0;
    assign lane[0].bad    = 1'b0;
    assign lane[0].rank   = '0;
    assign valid[0]       = i_valid;
    assign o_stall        = stall[0];

    assign stall[pri_pkg::CAP] = i_stall;

    for (genvar g = 0; g < pri_pkg::CAP; g++) begin : g_cell
        pri_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (pri_pkg::POS_W'(g)),
            .i_size  (size_eff),
            .i_valid (valid[g]),
            .o_stall (stall[g]),
            .i_lane  (lane[g]),
            .o_valid (valid[g+1]),
            .i_stall (stall[g+1]),
            .o_lane  (lane[g+1])
        );
    end

    assign o_valid           = valid[pri_pkg::CAP];
    assign o_not_permutation = lane[pri_pkg::CAP].bad;
    assign o_index           = lane[pri_pkg::CAP].bad ? '0 : lane[pri_pkg::CAP].rank;

endmodule

`default_nettype wire

>>> hdl/pri_cell.sv
// One cell of the ranking chain: handles one position of the permutation.
// Depends on pri_pkg (t_lane, FACT, widths).
`default_nettype none

module pri_cell (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire  [pri_pkg::POS_W-1:0]  i_pos,
    input  wire  [pri_pkg::SIZE_W-1:0] i_size,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  pri_pkg::t_lane             i_lane,
    output logic                       o_valid,
    input  wire                        i_stall,
    output pri_pkg::t_lane             o_lane
);

    logic                         r_valid;
    pri_pkg::t_lane               r_lane;
    pri_pkg::t_lane               n_lane;
    logic [pri_pkg::NIB_W-1:0]    v;
    logic                         active;
    logic [pri_pkg::POS_W-1:0]    digit;
    logic [pri_pkg::INDEX_W-1:0]  prod;
    logic                         load;

    assign load    = !(r_valid && i_stall);
    assign o_stall = !load;
    assign o_valid = r_valid;
    assign o_lane  = r_lane;

    assign v      = i_lane.images[i_pos*pri_pkg::NIB_W +: pri_pkg::NIB_W];
    assign active = pri_pkg::SIZE_W'(i_pos) < i_size;

    // earlier positions holding a larger image
    always_comb begin
        digit = '0;
        for (int k = 0; k < pri_pkg::CAP; k++) begin
            if ((pri_pkg::POS_W'(k) < i_pos) &&
                (i_lane.images[k*pri_pkg::NIB_W +: pri_pkg::NIB_W] > v)) begin
                digit = digit + 1'b1;
            end
        end
    end

    assign prod = pri_pkg::INDEX_W'(digit) * pri_pkg::FACT[i_pos];

    always_comb begin
        n_lane = i_lane;
        if (active) begin
            n_lane.rank = i_lane.rank + prod;
            if ((v == '0) || (pri_pkg::SIZE_W'(v) > i_size)) begin
                n_lane.bad = 1'b1;
            end else begin
                if (i_lane.seen[v]) begin
                    n_lane.bad = 1'b1;
                end
                n_lane.seen[v] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_lane <= n_lane;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pri_checker.sv
// Port-level checks for permutation_rank_index, bound to the top level.
// Depends on pri_pkg for the index limit.
`default_nettype none

module pri_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_stall,
    input wire                         o_stall,
    input wire                         o_valid,
    input wire [pri_pkg::INDEX_W-1:0]  o_index,
    input wire                         o_not_permutation
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_index)
                               && $stable(o_not_permutation))
        else $error("stalled result changed");

    // back-pressure only when the chain is full and the receiver stalls
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_not_permutation |-> o_index == '0)
        else $error("index not zero on flagged input");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_index < pri_pkg::INDEX_LIMIT)
        else $error("index out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind permutation_rank_index pri_checker u_pri_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_stall           (i_stall),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .o_index           (o_index),
    .o_not_permutation (o_not_permutation)
);

`default_nettype wire

>>> sim/permutation_rank_index_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for permutation_rank_index: Lehmer ranks of packed permutations.
// Depends on pri_pkg and the permutation_rank_index RTL.

module permutation_rank_index_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LATENCY     = 8;

    typedef struct packed {
        logic [pri_pkg::INDEX_W-1:0] index;
        logic                        not_perm;
    } t_rank_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_wr_en = 1'b0;
    logic [pri_pkg::SIZE_W-1:0]   i_cfg_wr_data = '0;
    logic                         i_valid = 1'b0;
    logic [pri_pkg::IMG_W-1:0]    i_images = '0;
    logic                         i_stall = 1'b0;
    logic                         o_stall;
    logic                         o_valid;
    logic [pri_pkg::INDEX_W-1:0]  o_index;
    logic                         o_not_permutation;

    t_rank_result                 rank_expected [$];
    logic [pri_pkg::SIZE_W-1:0]   size_model = pri_pkg::ACTIVE_N_RST;
    logic [pri_pkg::SIZE_W-1:0]   size_now = pri_pkg::ACTIVE_N_RST;
    int                           fail_count = 0;
    int                           ranks_checked = 0;
    int                           flagged_count = 0;
    int                           size_writes = 0;
    int                           cycle_count = 0;
    int                           stall_left = 0;
    bit                           tx_idle_on = 1'b1;
    logic                         rx_idle_on = 1'b1;
    logic                         hold_rx = 1'b0;

    permutation_rank_index dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_images          (i_images),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_index           (o_index),
        .o_not_permutation (o_not_permutation)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // size register as the datapath sees it: 0 means 1, saturates at CAP
    function automatic int used_positions(input logic [pri_pkg::SIZE_W-1:0] size_reg);
        int n;
        n = size_reg;
        if (n < 1) n = 1;
        if (n > pri_pkg::CAP) n = pri_pkg::CAP;
        return n;
    endfunction

    function automatic t_rank_result lehmer_rank(input logic [pri_pkg::IMG_W-1:0] img,
                                                 input logic [pri_pkg::SIZE_W-1:0] size_reg);
        t_rank_result res;
        logic [pri_pkg::NIB_W-1:0] v [pri_pkg::NIBBLES];
        logic [pri_pkg::SEEN_W-1:0] seen;
        bit bad;
        int n;
        int digit;
        int fact;
        int rank;
        n = used_positions(size_reg);
        seen = '0;
        bad = 1'b0;
        fact = 1;
        rank = 0;
        for (int m = 0; m < n; m++) begin
            v[m] = img[pri_pkg::NIB_W*m +: pri_pkg::NIB_W];
            if (v[m] == 0 || v[m] > n) begin
                bad = 1'b1;
            end else begin
                if (seen[v[m]]) bad = 1'b1;
                seen[v[m]] = 1'b1;
            end
        end
        for (int m = 0; m < n && !bad; m++) begin
            digit = 0;
            if (m > 0) fact = fact * m;
            for (int k = 0; k < m; k++)
                if (v[k] > v[m]) digit++;
            rank += digit * fact;
        end
        res.index    = bad ? '0 : pri_pkg::INDEX_W'(rank);
        res.not_perm = bad;
        return res;
    endfunction

    // shuffled 1..n in the low nibbles, random junk above
    function automatic logic [pri_pkg::IMG_W-1:0] random_perm(input int n);
        logic [pri_pkg::NIB_W-1:0] vals [pri_pkg::NIBBLES];
        logic [pri_pkg::NIB_W-1:0] t;
        logic [pri_pkg::IMG_W-1:0] word;
        int j;
        for (int i = 0; i < pri_pkg::NIBBLES; i++) vals[i] = pri_pkg::NIB_W'(i + 1);
        for (int i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = vals[i];
            vals[i] = vals[j];
            vals[j] = t;
        end
        word = $urandom;
        for (int i = 0; i < n; i++) word[pri_pkg::NIB_W*i +: pri_pkg::NIB_W] = vals[i];
        return word;
    endfunction

    // mostly clean permutations; some pure noise, duplicates or out-of-range images
    function automatic logic [pri_pkg::IMG_W-1:0] mixed_perm(input int n);
        logic [pri_pkg::IMG_W-1:0] word;
        int p;
        int q;
        int pick;
        word = random_perm(n);
        pick = $urandom_range(0, 9);
        p = $urandom_range(0, n - 1);
        if (pick == 0) begin
            word = $urandom;
        end else if (pick == 1 && n > 1) begin
            q = (p + $urandom_range(1, n - 1)) % n;
            word[pri_pkg::NIB_W*p +: pri_pkg::NIB_W] = word[pri_pkg::NIB_W*q +: pri_pkg::NIB_W];
        end else if (pick == 2) begin
            word[pri_pkg::NIB_W*p +: pri_pkg::NIB_W] =
                $urandom_range(0, 1) ? pri_pkg::NIB_W'(0)
                                     : pri_pkg::NIB_W'($urandom_range(n + 1, 15));
        end
        return word;
    endfunction

    // receiver: random stall bursts, or a long hold when asked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else if (hold_rx) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // check results in order, then predict for each accepted transaction
    always @(posedge i_clk) begin
        t_rank_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (rank_expected.size() == 0) begin
                    $display("%0t: unexpected result, index %0d not_permutation %0b",
                             $time, o_index, o_not_permutation);
                    fail_count++;
                end else begin
                    want = rank_expected.pop_front();
                    ranks_checked++;
                    if (want.not_perm) flagged_count++;
                    if (o_index !== want.index) begin
                        $display("%0t: index expected %0d, actual %0d",
                                 $time, want.index, o_index);
                        fail_count++;
                    end
                    if (o_not_permutation !== want.not_perm) begin
                        $display("%0t: not_permutation expected %0b, actual %0b",
                                 $time, want.not_perm, o_not_permutation);
                        fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall) rank_expected.push_back(lehmer_rank(i_images, size_model));
            if (i_cfg_wr_en) size_model = i_cfg_wr_data;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     rank_expected.size());
            $display("Verification failed");
            $finish;
        end
    end

    // valid stays high after acceptance; the next call drives the next image, or settle() lowers it
    task automatic send_perm(input logic [pri_pkg::IMG_W-1:0] img);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_images <= img;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (rank_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_size(input logic [pri_pkg::SIZE_W-1:0] size);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= size;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        size_now = size;
        size_writes++;
    endtask

    task automatic test_directed();
        // reset size of 8: identity, reverse, bad images, all-ones and all-zeros
        send_perm(32'h8765_4321);
        send_perm(32'h1234_5678);
        send_perm(32'h2134_5678);
        send_perm(32'h8765_4320);
        send_perm(32'h8765_4329);
        send_perm(32'h8765_432F);
        send_perm(32'h8765_4311);
        send_perm(32'hFFFF_FFFF);
        send_perm(32'h0000_0000);
        // size zero behaves as one position
        set_size(4'd0);
        send_perm(32'h0000_0001);
        send_perm(32'hFFFF_FFF1);
        send_perm(32'h0000_0002);
        send_perm(32'h0000_0000);
        // oversize saturates to eight positions
        set_size(4'd15);
        send_perm(32'h1234_5678);
        send_perm(32'h8765_4321);
        set_size(4'd9);
        send_perm(32'h1876_5432);
        // upper nibbles ignored
        set_size(4'd3);
        send_perm(32'hABCD_E213);
        send_perm(32'h0000_0123);
        send_perm(32'h0000_0124);
        send_perm(32'h0000_0113);
        set_size(4'd1);
        send_perm(32'h0000_000F);
        settle();
    endtask

    task automatic test_random_sizes();
        logic [pri_pkg::SIZE_W-1:0] sizes [8] = '{4'd8, 4'd0, 4'd1, 4'd2,
                                                  4'd5, 4'd7, 4'd9, 4'd15};
        foreach (sizes[s]) begin
            set_size(sizes[s]);
            repeat (45) send_perm(mixed_perm(used_positions(size_now)));
        end
        settle();
    endtask

    task automatic test_backpressure();
        set_size(4'd8);
        tx_idle_on = 1'b0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (80) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
            repeat (30) send_perm(mixed_perm(pri_pkg::CAP));
        join
        settle();
    endtask

    task automatic test_streaming();
        set_size(4'd6);
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        repeat (50) send_perm(mixed_perm(6));
        set_size(4'd8);
        repeat (50) send_perm(mixed_perm(8));
        settle();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_sizes();
        test_backpressure();
        test_streaming();
        if (rank_expected.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, rank_expected.size());
            fail_count++;
        end
        $display("Checked %0d ranks (%0d flagged as non-permutations) over %0d size writes,",
                 ranks_checked, flagged_count, size_writes);
        $display("including size 0 and saturated sizes, random stalls and a long output hold.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/pri_pkg.sv
hdl/pri_cell.sv
hdl/permutation_rank_index.sv
hdl/pri_checker.sv
sim/permutation_rank_index_test.sv
